FILE: hw/rtl/rrrp_pkg.sv
package rrrp_pkg;

    // sizing of the placement tables
    localparam int MAX_NODES          = 16;
    localparam int MAX_DISKS_PER_NODE = 16;
    localparam int MAX_REPLICAS       = 8;
    localparam int RESULT_LIMIT       = 8;

    // fixed field widths
    localparam int DISK_W   = 32;
    localparam int CURSOR_W = 32;
    localparam int CFG_W    = 5;
    localparam int REP_W    = 4;

    localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SLOT_IDX_W = (MAX_DISKS_PER_NODE > 1) ? $clog2(MAX_DISKS_PER_NODE) : 1;
    localparam int NCNT_W     = $clog2(MAX_NODES + 1);
    localparam int DCNT_W     = $clog2(MAX_DISKS_PER_NODE + 1);
    localparam int DIV_MAX    = (MAX_NODES > MAX_DISKS_PER_NODE) ? MAX_NODES
                                                                 : MAX_DISKS_PER_NODE;
    localparam int DIV_W      = $clog2(DIV_MAX + 1);

    localparam int TABLE_DEPTH = MAX_NODES * MAX_DISKS_PER_NODE;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // remainder unit retires this many dividend bits per cycle
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = CURSOR_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_TABLE = 2'd1,
        REQ_COUNT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_CHOSEN  = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_LOADED  = 2'd2
    } status_t;

    localparam logic CFG_POOL_NODES = 1'b0;
    localparam logic CFG_SOLO_MODE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_CHECK,
        S_BASE_MOD,
        S_SCAN,
        S_PICK,
        S_MOD_WAIT,
        S_READ,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [CURSOR_W-1:0] dividend;
        logic [DIV_W-1:0]    divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] remainder;
    } mod_rsp_t;

    function automatic logic [TABLE_AW-1:0] table_addr(
        input logic [NODE_IDX_W-1:0] nd,
        input logic [SLOT_IDX_W-1:0] sl
    );
        logic [TABLE_AW-1:0] base;
        base = TABLE_AW'(nd) * TABLE_AW'(MAX_DISKS_PER_NODE);
        return base + TABLE_AW'(sl);
    endfunction

endpackage

FILE: hw/rtl/rrrp_ram.sv
module rrrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rrrp_mod_unit.sv
module rrrp_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  rrrp_pkg::mod_req_t req,
    output rrrp_pkg::mod_rsp_t rsp
);
    import rrrp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [CURSOR_W-1:0]  num_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;

    // restoring remainder, a few bits per cycle
    always_comb
    begin
        logic [DIV_W:0] t;
        rem_next = rem_reg;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            t = {rem_next, num_reg[CURSOR_W-1-k]};
            if (t >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(t - {1'b0, div_reg});
            end
            else
            begin
                rem_next = t[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MOD_CNT_W'(MOD_STEPS - 1);
            num_reg  <= req.dividend;
            div_reg  <= req.divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[CURSOR_W-1-MOD_STEP_BITS:0], {MOD_STEP_BITS{1'b0}}};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/round_robin_replica_placer.sv
// round robin replica placer
//
// input channel (in_valid / in_stall) carries one request per transaction:
// a disk table write, a node disk count write, or an allocate. output channel
// (out_valid / out_stall) returns result transactions: one for a load or a
// rejected request, replica_count for a granted allocate, last marks the end.
// config port (cfg_we, cfg_index, cfg_wdata) sets the active node count and
// solo_mode; write it only while the block is idle.
//
// one request is worked at a time; in_stall is high until the sequencer is
// back in idle. every cursor modulo runs through one shared remainder unit
// (32 bits, 4 per cycle). a normal allocate runs one modulo on the pool
// cursor and one per replica, a solo allocate only one; an output stall
// lengthens either.
//
// reset clears all cursors, disk counts, config and state registers; the disk
// table ram and request context are not cleared. a stalled receiver holds the
// output register and the sequencer waits on it before placing the next result.
module round_robin_replica_placer (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  replica_count,
    input  logic [3:0]  node_index,
    input  logic [3:0]  slot_index,
    input  logic [31:0] disk_id,
    input  logic [4:0]  disk_num,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] chosen_disk,
    output logic [2:0]  replica_index,
    output logic        last
);
    import rrrp_pkg::*;

    // sequencer state
    state_t                state_reg, state_next;
    logic [REP_W-1:0]      reps_reg, reps_next;
    logic [REP_W-1:0]      idx_reg, idx_next;
    status_t               resp_reg, resp_next;
    logic [NODE_IDX_W-1:0] nd_reg, nd_next;
    logic [NODE_IDX_W-1:0] base_reg, base_next;
    logic [SLOT_IDX_W-1:0] slot_reg, slot_next;
    logic                  solo_reg, solo_next;

    // placement state
    logic [DCNT_W-1:0]   node_disks_reg [MAX_NODES];
    logic [DCNT_W-1:0]   node_disks_next [MAX_NODES];
    logic [CURSOR_W-1:0] node_cursor_reg [MAX_NODES];
    logic [CURSOR_W-1:0] node_cursor_next [MAX_NODES];
    logic [CURSOR_W-1:0] pool_cursor_reg, pool_cursor_next;

    // config registers
    logic [CFG_W-1:0] pool_nodes_reg;
    logic             solo_mode_reg;

    // output register
    logic              out_valid_reg;
    status_t           out_status_reg, out_status_next;
    logic [DISK_W-1:0] out_disk_reg, out_disk_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              out_free;

    // shared remainder unit and disk table
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;
    logic              ram_we;
    logic [TABLE_AW-1:0] ram_waddr;
    logic [TABLE_AW-1:0] ram_raddr;
    logic [DISK_W-1:0] ram_rdata;

    // derived values
    logic [NCNT_W-1:0]     n_eff;
    logic [DCNT_W-1:0]     c0;
    logic [DCNT_W-1:0]     c_nd;
    logic                  in_accept;
    logic                  is_last;
    logic [NODE_IDX_W-1:0] nd_wrap;
    logic [SLOT_IDX_W-1:0] slot_wrap;

    rrrp_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    rrrp_ram #(
        .WIDTH (DISK_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (disk_id),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // node count above the table size acts as the table size
    assign n_eff = (int'(pool_nodes_reg) > MAX_NODES) ? NCNT_W'(MAX_NODES)
                                                      : NCNT_W'(pool_nodes_reg);
    assign c0    = node_disks_reg[0];
    assign c_nd  = node_disks_reg[nd_reg];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = (int'(idx_reg) + 1 == int'(reps_reg));

    // cursors step round their node ring or disk ring
    assign nd_wrap   = (int'(nd_reg) + 1 == int'(n_eff)) ? '0 : nd_reg + 1'b1;
    assign slot_wrap = (int'(slot_reg) + 1 == int'(c0)) ? '0 : slot_reg + 1'b1;

    // table read follows the current node and slot; holds while stalled
    assign ram_raddr = table_addr(solo_reg ? '0 : nd_reg, slot_reg);

    always_comb
    begin
        state_next           = state_reg;
        reps_next            = reps_reg;
        idx_next             = idx_reg;
        resp_next            = resp_reg;
        nd_next              = nd_reg;
        base_next            = base_reg;
        slot_next            = slot_reg;
        solo_next            = solo_reg;
        pool_cursor_next     = pool_cursor_reg;
        node_disks_next      = node_disks_reg;
        node_cursor_next     = node_cursor_reg;
        ram_we               = 1'b0;
        ram_waddr            = table_addr(NODE_IDX_W'(node_index), SLOT_IDX_W'(slot_index));
        mod_req              = '0;
        out_load             = 1'b0;
        out_status_next      = STAT_CHOSEN;
        out_disk_next        = '0;
        out_idx_next         = '0;
        out_last_next        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (req_t'(req_type))
                        REQ_TABLE:
                        begin
                            state_next = S_RESP;
                            if (int'(node_index) >= MAX_NODES ||
                                int'(slot_index) >= MAX_DISKS_PER_NODE)
                            begin
                                resp_next = STAT_NOSPACE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                resp_next = STAT_LOADED;
                            end
                        end
                        REQ_COUNT:
                        begin
                            state_next = S_RESP;
                            if (int'(node_index) >= MAX_NODES)
                            begin
                                resp_next = STAT_NOSPACE;
                            end
                            else
                            begin
                                resp_next = STAT_LOADED;
                                node_disks_next[NODE_IDX_W'(node_index)] =
                                    (int'(disk_num) > MAX_DISKS_PER_NODE)
                                        ? DCNT_W'(MAX_DISKS_PER_NODE)
                                        : DCNT_W'(disk_num);
                            end
                        end
                        REQ_ALLOC:
                        begin
                            reps_next  = replica_count;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = resp_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_CHECK:
            begin
                resp_next = STAT_NOSPACE;
                idx_next  = '0;
                if (reps_reg == '0 || int'(reps_reg) > MAX_REPLICAS ||
                    int'(reps_reg) > RESULT_LIMIT)
                begin
                    state_next = S_RESP;
                end
                else if (solo_mode_reg && int'(n_eff) == 1)
                begin
                    // solo: consecutive disks of node 0 from its cursor
                    solo_next = 1'b1;
                    if (c0 == '0 || int'(c0) < int'(reps_reg))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = node_cursor_reg[0];
                        mod_req.divisor  = DIV_W'(c0);
                        state_next       = S_BASE_MOD;
                    end
                end
                else
                begin
                    solo_next = 1'b0;
                    if (n_eff == '0 || int'(n_eff) < int'(reps_reg))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = pool_cursor_reg;
                        mod_req.divisor  = DIV_W'(n_eff);
                        state_next       = S_BASE_MOD;
                    end
                end
            end

            S_BASE_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if (solo_reg)
                    begin
                        slot_next  = SLOT_IDX_W'(mod_rsp.remainder);
                        state_next = S_READ;
                    end
                    else
                    begin
                        nd_next    = NODE_IDX_W'(mod_rsp.remainder);
                        base_next  = NODE_IDX_W'(mod_rsp.remainder);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // every chosen node must hold a disk before any cursor moves
                if (c_nd == '0)
                begin
                    state_next = S_RESP;
                end
                else if (is_last)
                begin
                    idx_next   = '0;
                    nd_next    = base_reg;
                    state_next = S_PICK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    nd_next  = nd_wrap;
                end
            end

            S_PICK:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = node_cursor_reg[nd_reg];
                mod_req.divisor  = DIV_W'(c_nd);
                state_next       = S_MOD_WAIT;
            end

            S_MOD_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    slot_next  = SLOT_IDX_W'(mod_rsp.remainder);
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = STAT_CHOSEN;
                    out_disk_next   = ram_rdata;
                    out_idx_next    = idx_reg[2:0];
                    out_last_next   = is_last;
                    if (!solo_reg)
                    begin
                        node_cursor_next[nd_reg] = node_cursor_reg[nd_reg] + 1'b1;
                    end
                    if (is_last)
                    begin
                        if (solo_reg)
                        begin
                            node_cursor_next[0] = node_cursor_reg[0] + 1'b1;
                        end
                        else
                        begin
                            pool_cursor_next = pool_cursor_reg + 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (solo_reg)
                        begin
                            slot_next  = slot_wrap;
                            state_next = S_READ;
                        end
                        else
                        begin
                            nd_next    = nd_wrap;
                            state_next = S_PICK;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer and placement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pool_cursor_reg <= '0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                node_disks_reg[i]  <= '0;
                node_cursor_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            pool_cursor_reg <= pool_cursor_next;
            node_disks_reg  <= node_disks_next;
            node_cursor_reg <= node_cursor_next;
        end
    end

    // request context, no reset needed
    always_ff @(posedge clk)
    begin
        reps_reg <= reps_next;
        idx_reg  <= idx_next;
        resp_reg <= resp_next;
        nd_reg   <= nd_next;
        base_reg <= base_next;
        slot_reg <= slot_next;
        solo_reg <= solo_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_nodes_reg <= '0;
            solo_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_NODES: pool_nodes_reg <= cfg_wdata;
                CFG_SOLO_MODE:  solo_mode_reg  <= cfg_wdata[0];
                default:        pool_nodes_reg <= pool_nodes_reg;
            endcase
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_disk_reg   <= out_disk_next;
            out_idx_reg    <= out_idx_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign chosen_disk   = out_disk_reg;
    assign replica_index = out_idx_reg;
    assign last          = out_last_reg;

endmodule
